// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/bdclp_pkg.sv
// shared types and constants of the button debounce and long press block
package bdclp_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int TIME_W      = 16;
    localparam int LEVEL_W     = 3;
    localparam int IDX_W       = 2;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = TIME_W'(20);
    localparam logic [TIME_W-1:0] LONG_RESET     = TIME_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        EV_DOWN    = 2'd0,
        EV_CLICK   = 2'd1,
        EV_LONG    = 2'd2,
        EV_RELEASE = 2'd3
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event code;
    } t_lane_ev;

endpackage

// File: sv/bdclp_lane.sv
// one button lane: status, held-time accumulator and event decision
module bdclp_lane
    import bdclp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tick,
    input  logic              i_held,
    input  logic [TIME_W-1:0] i_span,
    input  logic [TIME_W-1:0] i_debounce,
    input  logic [TIME_W-1:0] i_long,
    output t_lane_ev          o_ev
);

    typedef enum logic [1:0] {
        ST_UP      = 2'd0,
        ST_PRESSED = 2'd1,
        ST_LONG    = 2'd2
    } t_status;

    t_status           r_status;
    t_status           n_status;
    logic [TIME_W-1:0] r_held;
    logic [TIME_W-1:0] n_held;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] sat;

    assign sum = {1'b0, r_held} + {1'b0, i_span};
    assign sat = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

    always_comb begin
        n_status   = r_status;
        n_held     = r_held;
        o_ev.valid = 1'b0;
        o_ev.code  = EV_DOWN;
        unique case (r_status)
            ST_PRESSED: begin
                if (i_held) begin
                    n_held = sat;
                    if (sat >= i_long) begin
                        n_status   = ST_LONG;
                        o_ev.valid = 1'b1;
                        o_ev.code  = EV_LONG;
                    end
                end else begin
                    n_held     = '0;
                    n_status   = ST_UP;
                    o_ev.valid = 1'b1;
                    o_ev.code  = EV_CLICK;
                end
            end
            ST_LONG: begin
                if (i_held) begin
                    n_held = sat;
                end else begin
                    n_held     = '0;
                    n_status   = ST_UP;
                    o_ev.valid = 1'b1;
                    o_ev.code  = EV_RELEASE;
                end
            end
            default: begin
                n_held   = i_held ? sat : '0;
                n_status = ST_UP;
                if (n_held >= i_debounce) begin
                    n_status   = ST_PRESSED;
                    o_ev.valid = 1'b1;
                    o_ev.code  = EV_DOWN;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= ST_UP;
            r_held   <= '0;
        end else if (i_tick) begin
            r_status <= n_status;
            r_held   <= n_held;
        end
    end

endmodule

// File: sv/bdclp_merge.sv
// merge stage: holds the events of one tick and sends them in button order
module bdclp_merge
    import bdclp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_lane_ev         i_ev [NUM_BUTTONS],
    input  logic             i_out_ready,
    output logic             o_free,
    output logic             o_out_valid,
    output logic [IDX_W-1:0] o_button_index,
    output logic [1:0]       o_event_code,
    output logic             o_last_event
);

    logic [NUM_BUTTONS-1:0] r_pend;
    logic [NUM_BUTTONS-1:0] n_pend;
    t_event                 r_code [NUM_BUTTONS];
    logic [IDX_W-1:0]       sel;
    logic [NUM_BUTTONS-1:0] sel_mask;
    logic [NUM_BUTTONS-1:0] rest;
    logic                   take;

    // lowest pending lane
    always_comb begin
        sel      = '0;
        sel_mask = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                sel      = IDX_W'(i);
                sel_mask = NUM_BUTTONS'(1) << i;
            end
        end
    end

    assign rest           = r_pend & ~sel_mask;
    assign o_out_valid    = |r_pend;
    assign o_button_index = sel;
    assign o_event_code   = r_code[sel];
    assign o_last_event   = (rest == '0);
    assign take           = o_out_valid && i_out_ready;
    assign o_free         = !o_out_valid || (take && o_last_event);

    always_comb begin
        n_pend = take ? rest : r_pend;
        if (i_load) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                n_pend[i] = i_ev[i].valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_code[i] <= i_ev[i].code;
            end
        end
    end

endmodule

// File: sv/button_debounce_click_long_press.sv
// top level of the button debounce, click and long press detector
//
//  channel | valid        | ready        | word
//  --------+--------------+--------------+-----------------------------------------
//  tick in | i_in_valid   | o_in_ready   | i_elapsed, i_pressed_levels
//  event   | o_out_valid  | i_out_ready  | o_button_index, o_event_code, o_last_event
//  config  | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a tick with k events puts k words on the event port, one word per event;
// a tick with no event puts none. the next tick is taken in the cycle
// the last word of the previous one leaves, set by the single merge register.
// all lanes update in the cycle the tick is taken. synchronous active-low
// reset clears status, held times and pending words and loads register defaults.
// a stalled event port holds the current word and blocks new ticks.
module button_debounce_click_long_press
    import bdclp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [TIME_W-1:0]    i_elapsed,
    input  logic [LEVEL_W-1:0]   i_pressed_levels,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [IDX_W-1:0]     o_button_index,
    output logic [1:0]           o_event_code,
    output logic                 o_last_event,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    logic [TIME_W-1:0] r_debounce;
    logic [TIME_W-1:0] r_long;
    logic              tick;
    t_lane_ev          lane_ev [NUM_BUTTONS];

    assign o_cfg_ready = 1'b1;
    assign tick        = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_long     <= LONG_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_DEBOUNCE) begin
                r_debounce <= i_cfg_data;
            end else if (i_cfg_index == REG_LONG) begin
                r_long <= i_cfg_data;
            end
        end
    end

    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        bdclp_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_tick     (tick),
            .i_held     (i_pressed_levels[g]),
            .i_span     (i_elapsed),
            .i_debounce (r_debounce),
            .i_long     (r_long),
            .o_ev       (lane_ev[g])
        );
    end

    bdclp_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (tick),
        .i_ev           (lane_ev),
        .i_out_ready    (i_out_ready),
        .o_free         (o_in_ready),
        .o_out_valid    (o_out_valid),
        .o_button_index (o_button_index),
        .o_event_code   (o_event_code),
        .o_last_event   (o_last_event)
    );

endmodule

// File: sv/bdclp_checker.sv
// port-level checks of the detector and their binding
`include "assert_macros.svh"

module bdclp_checker
    import bdclp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [IDX_W-1:0]     o_button_index,
    input logic [1:0]           o_event_code,
    input logic                 o_last_event
);

    // a tick is taken only when the last word of the previous one leaves
    `ASSERT_SAME(a_in_after_last, i_in_valid && o_in_ready && o_out_valid, o_last_event && i_out_ready)

    // more words of the same tick follow
    `ASSERT_NEXT(a_burst_cont, o_out_valid && !o_last_event && i_out_ready, o_out_valid)

    // stalled word holds
    `ASSERT_NEXT(a_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_button_index) && $stable(o_event_code))

    // index stays within the buttons
    `ASSERT_SAME(a_index, o_out_valid, o_button_index < IDX_W'(NUM_BUTTONS))

endmodule

bind button_debounce_click_long_press bdclp_checker u_bdclp_checker (.*);

// File: verif/tb_button_debounce_click_long_press.sv
// self-checking testbench of the button debounce, click and long press detector
module tb_button_debounce_click_long_press;
    import bdclp_pkg::*;

    localparam int RUN_LIMIT       = 600000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CALM_SPAN       = 256;
    localparam int NUM_PHASES      = 7;
    localparam int TICKS_PER_PHASE = 58;
    localparam int SQUEEZE_PHASE   = 3;
    localparam int SQUEEZE_CYCLES  = 300;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        BTN_UP      = 2'd0,
        BTN_PRESSED = 2'd1,
        BTN_LONG    = 2'd2,
        BTN_SPARE   = 2'd3
    } t_btn_state;

    typedef struct packed {
        logic [IDX_W-1:0] button;
        t_event           code;
        logic             last;
    } t_btn_event;

    typedef struct packed {
        logic                   is_cfg;
        logic [TIME_W-1:0]      value;
        logic [LEVEL_W-1:0]     sel;
        logic                   typed;
        logic [NUM_BUTTONS-1:0] mask;
        t_event                 code;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [TIME_W-1:0]    i_elapsed = '0;
    logic [LEVEL_W-1:0]   i_pressed_levels = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [IDX_W-1:0]     o_button_index;
    logic [1:0]           o_event_code;
    logic                 o_last_event;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TIME_W-1:0]    i_cfg_data = '0;

    t_btn_state        btn_st [NUM_BUTTONS];
    logic [TIME_W-1:0] held_acc [NUM_BUTTONS];
    logic [TIME_W-1:0] cfg_debounce;
    logic [TIME_W-1:0] cfg_long;

    t_btn_event pending_events [$];
    int         cycle_cnt = 0;
    int         mismatches = 0;
    int         ticks_sent = 0;
    int         words_checked = 0;
    int         cfg_writes = 0;
    bit         squeeze_req = 1'b0;

    button_debounce_click_long_press DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_elapsed        (i_elapsed),
        .i_pressed_levels (i_pressed_levels),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_button_index   (o_button_index),
        .o_event_code     (o_event_code),
        .o_last_event     (o_last_event),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int pick_idle();
        int r;
        if (((cycle_cnt / CALM_SPAN) % 4) == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // updates every button for one tick, puts the events it raises in evs and returns their number
    function automatic int advance_buttons(input logic [TIME_W-1:0] span,
                                           input logic [LEVEL_W-1:0] levels,
                                           output t_btn_event evs [NUM_BUTTONS]);
        int                n;
        int                b;
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] grown;
        logic              fire;
        t_event            code;
        n = 0;
        for (b = 0; b < NUM_BUTTONS; b++) begin
            evs[b] = '0;
        end
        for (b = 0; b < NUM_BUTTONS; b++) begin
            fire = 1'b0;
            code = EV_DOWN;
            sum = {1'b0, held_acc[b]} + {1'b0, span};
            grown = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            case (btn_st[b])
                BTN_PRESSED: begin
                    if (levels[b]) begin
                        held_acc[b] = grown;
                        if (held_acc[b] >= cfg_long) begin
                            btn_st[b] = BTN_LONG;
                            fire = 1'b1;
                            code = EV_LONG;
                        end
                    end else begin
                        held_acc[b] = '0;
                        btn_st[b] = BTN_UP;
                        fire = 1'b1;
                        code = EV_CLICK;
                    end
                end
                BTN_LONG: begin
                    if (levels[b]) begin
                        held_acc[b] = grown;
                    end else begin
                        held_acc[b] = '0;
                        btn_st[b] = BTN_UP;
                        fire = 1'b1;
                        code = EV_RELEASE;
                    end
                end
                default: begin
                    btn_st[b] = BTN_UP;
                    held_acc[b] = levels[b] ? grown : '0;
                    if (held_acc[b] >= cfg_debounce) begin
                        btn_st[b] = BTN_PRESSED;
                        fire = 1'b1;
                        code = EV_DOWN;
                    end
                end
            endcase
            if (fire) begin
                evs[n] = '{button: IDX_W'(b), code: code, last: 1'b0};
                n++;
            end
        end
        if (n > 0) evs[n-1].last = 1'b1;
        return n;
    endfunction

    function automatic t_row tick_row(input logic [TIME_W-1:0] span,
                                      input logic [LEVEL_W-1:0] levels);
        return '{is_cfg: 1'b0, value: span, sel: levels, typed: 1'b0, mask: '0,
                 code: EV_DOWN};
    endfunction

    function automatic t_row typed_row(input logic [TIME_W-1:0] span,
                                       input logic [LEVEL_W-1:0] levels,
                                       input logic [NUM_BUTTONS-1:0] mask,
                                       input t_event code);
        return '{is_cfg: 1'b0, value: span, sel: levels, typed: 1'b1, mask: mask,
                 code: code};
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [TIME_W-1:0] val);
        return '{is_cfg: 1'b1, value: val, sel: LEVEL_W'(idx), typed: 1'b0, mask: '0,
                 code: EV_DOWN};
    endfunction

    task automatic send_tick(input logic [TIME_W-1:0] span,
                             input logic [LEVEL_W-1:0] levels,
                             input int gap,
                             input logic typed,
                             input logic [NUM_BUTTONS-1:0] mask,
                             input t_event code);
        t_btn_event evs [NUM_BUTTONS];
        int         n;
        int         b;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_elapsed <= span;
        i_pressed_levels <= levels;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
        n = advance_buttons(span, levels, evs);
        if (typed) begin
            n = 0;
            for (b = 0; b < NUM_BUTTONS; b++) begin
                if (mask[b]) begin
                    evs[n] = '{button: IDX_W'(b), code: code, last: 1'b0};
                    n++;
                end
            end
            if (n > 0) evs[n-1].last = 1'b1;
        end
        for (b = 0; b < n; b++) begin
            pending_events.push_back(evs[b]);
        end
    endtask

    // waits for the block to drain before touching a register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_DEBOUNCE) cfg_debounce = val;
        else if (idx == REG_LONG) cfg_long = val;
        cfg_writes++;
    endtask

    task automatic check_word();
        t_btn_event want;
        words_checked++;
        if (pending_events.size() == 0) begin
            $error("event word with nothing pending: button %0d code %0d last %0d",
                   o_button_index, o_event_code, o_last_event);
            mismatches++;
        end else begin
            want = pending_events.pop_front();
            if (o_button_index !== want.button) begin
                $error("button_index expected %0d actual %0d", want.button, o_button_index);
                mismatches++;
            end
            if (o_event_code !== want.code) begin
                $error("event_code expected %0d actual %0d", want.code, o_event_code);
                mismatches++;
            end
            if (o_last_event !== want.last) begin
                $error("last_event expected %0d actual %0d", want.last, o_last_event);
                mismatches++;
            end
        end
    endtask

    // event port: random stalls plus one long hold-off on request
    initial begin
        int  hold_left;
        int  g;
        bit  squeeze_done;
        hold_left = 0;
        squeeze_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_word();
            if (squeeze_req && !squeeze_done) begin
                squeeze_done = 1'b1;
                hold_left = SQUEEZE_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                g = pick_idle();
                i_out_ready <= (g == 0);
                hold_left = (g == 0) ? 0 : g - 1;
            end
        end
    end

    initial begin
        t_row              dir_rows [$];
        logic [LEVEL_W-1:0] hold_pattern;
        logic [LEVEL_W-1:0] levels;
        logic [TIME_W-1:0]  span;
        logic [TIME_W-1:0]  deb;
        logic [TIME_W-1:0]  lng;
        int                 span_hi;
        int                 ph;
        int                 k;
        int                 b;
        int                 sel;
        int                 gap;

        for (b = 0; b < NUM_BUTTONS; b++) begin
            btn_st[b] = BTN_UP;
            held_acc[b] = '0;
        end
        cfg_debounce = DEBOUNCE_RESET;
        cfg_long = LONG_RESET;
        hold_pattern = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_rows = '{
            typed_row(16'd0, 3'b000, 3'b000, EV_DOWN),
            typed_row(16'hFFFF, 3'b111, 3'b111, EV_DOWN),
            typed_row(16'd0, 3'b111, 3'b111, EV_LONG),
            typed_row(16'hFFFF, 3'b111, 3'b000, EV_DOWN),
            typed_row(16'd1, 3'b000, 3'b111, EV_RELEASE),
            tick_row(16'd19, 3'b001),
            tick_row(16'd1, 3'b001),
            tick_row(16'd5, 3'b000),
            reg_row(REG_DEBOUNCE, 16'd0),
            typed_row(16'd0, 3'b000, 3'b111, EV_DOWN),
            typed_row(16'd0, 3'b000, 3'b111, EV_CLICK),
            reg_row(REG_LONG, 16'd0),
            reg_row(REG_DEBOUNCE, 16'd1),
            tick_row(16'd1, 3'b010),
            tick_row(16'd0, 3'b000),
            tick_row(16'd1, 3'b111),
            tick_row(16'd0, 3'b101),
            reg_row(REG_SPARE_A, 16'd7),
            reg_row(REG_SPARE_B, 16'hFFFF),
            reg_row(REG_DEBOUNCE, 16'hFFFF),
            reg_row(REG_LONG, 16'hFFFF),
            tick_row(16'hFFFE, 3'b111),
            tick_row(16'd1, 3'b111),
            tick_row(16'hFFFF, 3'b111),
            tick_row(16'd0, 3'b000),
            tick_row(16'h5555, 3'b110),
            tick_row(16'hAAAA, 3'b011)
        };
        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg)
                write_reg(dir_rows[r].sel[CFG_IDX_W-1:0], dir_rows[r].value);
            else
                send_tick(dir_rows[r].value, dir_rows[r].sel, pick_idle(),
                          dir_rows[r].typed, dir_rows[r].mask, dir_rows[r].code);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    deb = 16'd1;
                    lng = 16'd1;
                    span_hi = 5;
                end
                1: begin
                    deb = 16'hFFFF;
                    lng = 16'hFFFF;
                    span_hi = 20000;
                end
                NUM_PHASES - 1: begin
                    deb = 16'($urandom_range(0, 65535));
                    lng = 16'($urandom_range(0, 65535));
                    span_hi = 8000;
                end
                default: begin
                    deb = 16'($urandom_range(1, 40));
                    lng = 16'($urandom_range(1, 400));
                    span_hi = 30;
                end
            endcase
            if (ph % 2 == 0) begin
                write_reg(REG_DEBOUNCE, deb);
                write_reg(REG_LONG, lng);
            end else begin
                write_reg(REG_LONG, lng);
                write_reg(REG_DEBOUNCE, deb);
            end
            for (k = 0; k < TICKS_PER_PHASE; k++) begin
                if (ph == SQUEEZE_PHASE && k == 10) squeeze_req = 1'b1;
                // buttons stay put for several ticks, with some noise ticks
                for (b = 0; b < NUM_BUTTONS; b++) begin
                    if ($urandom_range(0, 5) == 0) hold_pattern[b] = ~hold_pattern[b];
                end
                levels = ($urandom_range(0, 9) == 0) ? LEVEL_W'($urandom) : hold_pattern;
                sel = $urandom_range(0, 19);
                if (sel == 0) span = '0;
                else if (sel == 1) span = '1;
                else if (sel < 4) span = 16'($urandom);
                else span = 16'($urandom_range(1, span_hi));
                gap = (ph == SQUEEZE_PHASE && k >= 10 && k < 40) ? 0 : pick_idle();
                send_tick(span, levels, gap, 1'b0, '0, EV_DOWN);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d ticks over %0d register writes, extremes and random settings",
                 ticks_sent, cfg_writes);
        $display("checked %0d event words under random stalls and one long event hold-off",
                 words_checked);
        if (mismatches == 0 && pending_events.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/bdclp_pkg.sv
sv/bdclp_lane.sv
sv/bdclp_merge.sv
sv/button_debounce_click_long_press.sv
sv/bdclp_checker.sv
verif/tb_button_debounce_click_long_press.sv
